>>> rtl/core/mvt_pkg.sv
package mvt_pkg;

  // Element width of every vector and matrix entry (signed fixed point)
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIM     = 4;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;

  // Input mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  // Operation tag attached by the front end
  typedef enum logic {
    OP_LOAD,
    OP_XFORM
  } op_e;

  // Queue word between front and back
  typedef struct packed {
    op_e              op;
    logic [ROW_W-1:0] row_index;
    data_t            in_x;
    data_t            in_y;
    data_t            in_z;
    data_t            in_w;
  } item_t;

endpackage

>>> rtl/core/mvt_if.sv
// Input channel: one load or transform word
interface mvt_vec_if import mvt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  row_index;
  data_t       in_x;
  data_t       in_y;
  data_t       in_z;
  data_t       in_w;

  modport source (output valid, mode, row_index, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, mode, row_index, in_x, in_y, in_z, in_w, output ready);
endinterface

// Output channel: one transformed vector word
interface mvt_res_if import mvt_pkg::*; ();
  logic        valid;
  logic        ready;
  data_t       out_x;
  data_t       out_y;
  data_t       out_z;
  data_t       out_w;
  logic        saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

>>> rtl/core/mvt_front.sv
module mvt_front import mvt_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_vec_if.sink   vec_i,
  output logic      head_valid_o,
  output item_t     head_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t             queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;
  item_t             item_in;

  // Classify the incoming word
  always_comb begin
    item_in.op        = (vec_i.mode == MODE_XFORM) ? OP_XFORM : OP_LOAD;
    item_in.row_index = vec_i.row_index;
    item_in.in_x      = vec_i.in_x;
    item_in.in_y      = vec_i.in_y;
    item_in.in_z      = vec_i.in_z;
    item_in.in_w      = vec_i.in_w;
  end

  assign vec_i.ready  = (count_q != CntW'(QueueDepth));
  assign push         = vec_i.valid && vec_i.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = queue_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/core/mvt_back.sv
module mvt_back import mvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  item_t     head_i,
  output logic      pop_o,
  mvt_res_if.source res_o
);

  localparam data_t One = data_t'(64'(1) << FRAC_BITS);

  data_t                    mat_q   [DIM][DIM];
  data_t                    vec     [DIM];
  logic signed [PROD_W-1:0] prod_q  [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_q  [DIM][2];
  logic signed [SUM_W-1:0]  sum_q   [DIM];
  logic signed [SUM_W-1:0]  shifted [DIM];
  data_t                    sat_val [DIM];
  logic [DIM-1:0]           clip;
  logic                     prod_vld_q, pair_vld_q, sum_vld_q, out_vld_q;
  data_t                    out_q   [DIM];
  logic                     sat_q;
  logic                     en;
  logic                     load_wr;
  logic                     xform;

  // Whole pipeline advances unless the output word is stalled
  assign en      = !out_vld_q || res_o.ready;
  assign pop_o   = en && head_valid_i;
  assign load_wr = pop_o && (head_i.op == OP_LOAD);
  assign xform   = pop_o && (head_i.op == OP_XFORM);

  assign vec[0] = head_i.in_x;
  assign vec[1] = head_i.in_y;
  assign vec[2] = head_i.in_z;
  assign vec[3] = head_i.in_w;

  // Matrix storage, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat_q[r][c] <= (r == c) ? One : '0;
        end
      end
    end else if (load_wr) begin
      for (int c = 0; c < DIM; c++) begin
        mat_q[head_i.row_index][c] <= vec[c];
      end
    end
  end

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      pair_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      prod_vld_q <= xform;
      pair_vld_q <= prod_vld_q;
      sum_vld_q  <= pair_vld_q;
      out_vld_q  <= sum_vld_q;
    end
  end

  // Stage 1: sixteen products, stage 2: pair sums, stage 3: row sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_q[r][c] <= mat_q[r][c] * vec[c];
        end
        pair_q[r][0] <= PAIR_W'(prod_q[r][0]) + PAIR_W'(prod_q[r][1]);
        pair_q[r][1] <= PAIR_W'(prod_q[r][2]) + PAIR_W'(prod_q[r][3]);
        sum_q[r]     <= SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      end
    end
  end

  // Floor shift and clip to the element range
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      shifted[r] = sum_q[r] >>> FRAC_BITS;
      clip[r]    = (shifted[r][SUM_W-1:DATA_W-1] != '0) &&
                   (shifted[r][SUM_W-1:DATA_W-1] != '1);
      if (!clip[r]) begin
        sat_val[r] = shifted[r][DATA_W-1:0];
      end else if (shifted[r][SUM_W-1]) begin
        sat_val[r] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat_val[r] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        out_q[r] <= sat_val[r];
      end
      sat_q <= |clip;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.out_x     = out_q[0];
  assign res_o.out_y     = out_q[1];
  assign res_o.out_z     = out_q[2];
  assign res_o.out_w     = out_q[3];
  assign res_o.saturated = sat_q;

endmodule

>>> rtl/core/matrix4_vector_transform.sv
// A transform word passes the queue, products, pair sums, row sums and output
// register in that order, and waits in place while the output is stalled.
// Throughput: one word per cycle while the output is not stalled; load words
// take a slot but give no result. The 4-word queue keeps the input open while
// the output is held. Reset (async, active low) empties the queue and pipeline
// and sets the matrix to identity.
module matrix4_vector_transform import mvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_vec_if.sink   vec_i,
  mvt_res_if.source res_o
);

  logic  head_valid;
  item_t head;
  logic  pop;

  mvt_front #(
    .QueueDepth (4)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vec_i        (vec_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  mvt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

>>> rtl/core/mvt_checker.sv
module mvt_checker import mvt_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  res_valid_i,
  input logic  res_ready_i,
  input data_t out_x_i,
  input data_t out_y_i,
  input data_t out_z_i,
  input data_t out_w_i,
  input logic  saturated_i
);

  localparam data_t MaxVal = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t MinVal = {1'b1, {(DATA_W-1){1'b0}}};

  logic at_limit;

  assign at_limit = (out_x_i == MaxVal) || (out_x_i == MinVal) ||
                    (out_y_i == MaxVal) || (out_y_i == MinVal) ||
                    (out_z_i == MaxVal) || (out_z_i == MinVal) ||
                    (out_w_i == MaxVal) || (out_w_i == MinVal);

  // A held result word stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  // A held result word keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(out_x_i) && $stable(out_y_i) &&
    $stable(out_z_i) && $stable(out_w_i) && $stable(saturated_i))
    else $error("result payload changed while stalled");

  // The clip flag implies some element sits at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && saturated_i |-> at_limit)
    else $error("saturated set with no clipped element");

  // No result is offered while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind matrix4_vector_transform mvt_checker u_mvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .out_x_i     (res_o.out_x),
  .out_y_i     (res_o.out_y),
  .out_z_i     (res_o.out_z),
  .out_w_i     (res_o.out_w),
  .saturated_i (res_o.saturated)
);
